/* rtl/assert_macros.svh */
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge, skipped while reset is high.
`define GLPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the next edge, skipped while reset is high.
`define GLPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked on the next edge, also live during reset.
`define GLPF_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/glpf_pkg.sv */
// Package: types and fixed constants of the grid local peak finder.
`timescale 1ns / 1ps

package glpf_pkg;

  localparam int MAX_WIDTH = 32;
  localparam int MAX_ROWS  = 1024;
  localparam int VAL_W     = 16;
  localparam int COL_W     = 5;
  localparam int ROW_W     = 10;
  localparam int CFG_W     = 6;

  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(MAX_ROWS - 1);

  // Request codes
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [VAL_W-1:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] peak_row;
    logic [COL_W-1:0] peak_col;
  } out_item_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic             flush;      // flush beat, stores nothing
    logic [VAL_W-1:0] value;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;        // row of the cell being decided
    logic             decide;     // cell above exists and column in range
    logic             has_right;  // right neighbor inside the row
    logic             has_up;     // upper neighbor exists
    logic             rotate;     // data beat that closes a row
  } cmd_t;

endpackage

/* rtl/glpf_front.sv */
// Front end: accepts item beats, keeps row/column counters, classifies each item.
`timescale 1ns / 1ps

module glpf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [glpf_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          item_valid,
  input  glpf_pkg::in_item_t            item,
  output logic                          item_stall,
  input  logic                          queue_full,
  output logic                          push,
  output glpf_pkg::cmd_t                cmd
);

  logic [glpf_pkg::CFG_W-1:0] grid_width;
  logic [glpf_pkg::COL_W-1:0] col_count;
  logic [glpf_pkg::ROW_W-1:0] row_count;
  logic [glpf_pkg::COL_W-1:0] col_count_next;
  logic [glpf_pkg::ROW_W-1:0] row_count_next;

  logic [glpf_pkg::CFG_W-1:0] eff_width;
  logic [glpf_pkg::CFG_W-1:0] col_ext;
  logic [glpf_pkg::CFG_W-1:0] col_plus;
  logic                       row_end;
  logic                       flush;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;
  assign flush      = (item.req_type == glpf_pkg::REQ_FLUSH);

  // Clamp the configured width to the supported range
  always_comb begin
    if (grid_width < glpf_pkg::WIDTH_MIN) begin
      eff_width = glpf_pkg::WIDTH_MIN;
    end else if (grid_width > glpf_pkg::WIDTH_MAX) begin
      eff_width = glpf_pkg::WIDTH_MAX;
    end else begin
      eff_width = grid_width;
    end
  end

  assign col_ext  = {1'b0, col_count};
  assign col_plus = col_ext + 1'b1;
  assign row_end  = (col_plus >= eff_width);

  // Classification of the current beat
  always_comb begin
    cmd.flush     = flush;
    cmd.value     = item.cell_value;
    cmd.col       = col_count;
    cmd.row       = row_count - 1'b1;
    cmd.decide    = (col_ext < eff_width) && (row_count != '0);
    cmd.has_right = (col_plus < eff_width);
    cmd.has_up    = (row_count >= glpf_pkg::ROW_W'(2));
    cmd.rotate    = row_end && !flush;
  end

  // Counter update: a flush closing a row ends the frame
  always_comb begin
    col_count_next = col_count + 1'b1;
    row_count_next = row_count;
    if (row_end) begin
      col_count_next = '0;
      if (flush) begin
        row_count_next = '0;
      end else if (row_count != glpf_pkg::ROW_LAST) begin
        row_count_next = row_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= glpf_pkg::WIDTH_RESET;
      col_count  <= '0;
      row_count  <= '0;
    end else begin
      if (cfg_write) begin
        grid_width <= cfg_data;
      end
      if (push) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
    end
  end

endmodule

/* rtl/glpf_queue.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module glpf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  glpf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output glpf_pkg::cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  glpf_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/glpf_back.sv */
// Back end: three line buffers, per-column compares, registered peak output.
`timescale 1ns / 1ps

module glpf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  glpf_pkg::cmd_t        cmd,
  output logic                  cmd_pop,
  output logic                  peak_valid,
  input  logic                  peak_stall,
  output glpf_pkg::out_item_t   peak
);

  localparam int W = glpf_pkg::MAX_WIDTH;

  logic [glpf_pkg::VAL_W-1:0] upper      [W];
  logic [glpf_pkg::VAL_W-1:0] middle     [W];
  logic [glpf_pkg::VAL_W-1:0] lower      [W];
  logic [glpf_pkg::VAL_W-1:0] lower_next [W];

  logic [W-1:0] ge_left;
  logic [W-1:0] ge_right;
  logic [W-1:0] ge_up;
  logic [W-1:0] ge_low;
  logic         is_peak;

  // Work one command whenever the output register is free or draining
  assign cmd_pop = cmd_valid && (!peak_valid || !peak_stall);

  // Per-column compares against fixed neighbors
  for (genvar i = 0; i < W; i++) begin : g_lane
    if (i == 0) begin : g_first
      assign ge_left[i] = 1'b1;
    end else begin : g_left
      assign ge_left[i] = (middle[i] >= middle[i-1]);
    end
    if (i == W - 1) begin : g_last
      assign ge_right[i] = 1'b1;
    end else begin : g_right
      assign ge_right[i] = (middle[i] >= middle[i+1]);
    end
    assign ge_up[i]  = (middle[i] >= upper[i]);
    assign ge_low[i] = (middle[i] >= cmd.value);
  end

  assign is_peak = cmd.decide
                && ge_left[cmd.col]
                && (!cmd.has_right || ge_right[cmd.col])
                && (!cmd.has_up || ge_up[cmd.col])
                && (cmd.flush || ge_low[cmd.col]);

  // Data beats store into the row being received
  always_comb begin
    for (int i = 0; i < W; i++) begin
      lower_next[i] = lower[i];
      if (!cmd.flush && (cmd.col == glpf_pkg::COL_W'(i))) begin
        lower_next[i] = cmd.value;
      end
    end
  end

  // Line buffers; a row-closing data beat shifts the rows up
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < W; i++) begin
        upper[i]  <= '0;
        middle[i] <= '0;
        lower[i]  <= '0;
      end
    end else if (cmd_pop) begin
      for (int i = 0; i < W; i++) begin
        lower[i] <= lower_next[i];
        if (cmd.rotate) begin
          upper[i]  <= middle[i];
          middle[i] <= lower_next[i];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (cmd_pop) begin
      peak_valid <= is_peak;
    end else if (!peak_stall) begin
      peak_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      peak.peak_row <= cmd.row;
      peak.peak_col <= cmd.col;
    end
  end

endmodule

/* rtl/grid_local_peak_finder_top.sv */
// Top level of the grid local peak finder.
// Takes one item beat per clock: a grid value in row-major order or, after the last row,
// one flush beat per column. Each beat yields at most one peak beat, the coordinates of
// the cell above the current column when that cell is >= each of its existing four
// neighbors; peaks leave in row-major order. The front end classifies a beat in the cycle
// it is accepted and writes it into a QUEUE_DEPTH-entry command queue; the back end
// compares and updates its three line buffers one command per cycle unless stalled; an item
// beat is registered in the queue and its peak beat in the output register. item_stall
// rises only when the queue is full, which happens only while peak_stall holds the output
// register. cfg_data sets the row width (values below 2 act as 2, above 32 as 32); write it
// only while the block is idle. No clearing pass: the block takes items right after reset.
`timescale 1ns / 1ps

module grid_local_peak_finder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [glpf_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  glpf_pkg::in_item_t           item,
  output logic                         peak_valid,
  input  logic                         peak_stall,
  output glpf_pkg::out_item_t          peak
);

  logic           push;
  logic           queue_full;
  glpf_pkg::cmd_t front_cmd;
  logic           head_valid;
  glpf_pkg::cmd_t head_cmd;
  logic           pop;

  glpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  glpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  glpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (head_valid),
    .cmd        (head_cmd),
    .cmd_pop    (pop),
    .peak_valid (peak_valid),
    .peak_stall (peak_stall),
    .peak       (peak)
  );

endmodule

/* rtl/glpf_checker.sv */
// Port-level checker for the grid local peak finder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glpf_port_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_stall,
  input glpf_pkg::in_item_t          item,
  input logic                        peak_valid,
  input logic                        peak_stall,
  input glpf_pkg::out_item_t         peak
);

  // A stalled peak beat holds
  `GLPF_ASSERT_NEXT(a_peak_hold, peak_valid && peak_stall, peak_valid && $stable(peak), "peak beat changed while stalled")

  // A stalled item beat holds
  `GLPF_ASSERT_NEXT(a_item_hold, item_valid && item_stall, item_valid && $stable(item), "item beat changed while stalled")

  // Reset empties the queue and the output register
  `GLPF_ASSERT_RST(a_reset_clear, rst, !peak_valid && !item_stall, "not empty after reset")

  // With the output draining, the queue cannot fill up
  `GLPF_ASSERT_NEXT(a_no_fill, !peak_stall && !item_stall, !item_stall, "input stalled while output drains")

endmodule

bind grid_local_peak_finder_top glpf_port_checker u_glpf_checker (.*);
